>>> rtl/tmjs_pkg.sv
package tmjs_pkg;

  localparam int MAX_JOBS  = 32;
  localparam int TIME_BITS = 13;
  localparam int IDX_W     = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int TIME_W    = 13;
  localparam int JOB_NUM_W = 5;
  localparam int POS_W     = 5;

  typedef struct packed {
    logic [TIME_W-1:0] time_machine1;
    logic [TIME_W-1:0] time_machine2;
    logic              last_job;
  } in_item_t;

  typedef struct packed {
    logic [JOB_NUM_W-1:0] job_number;
    logic [POS_W-1:0]     position;
    logic                 last_in_order;
  } out_item_t;

  typedef struct packed {
    logic                 on_second;
    logic [TIME_BITS-1:0] min_time;
  } key_t;

  typedef struct packed {
    logic load;
    logic seq_start;
    logic scan;
    logic place;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic round_last;
    logic emit_last;
  } status_t;

endpackage

>>> rtl/tmjs_ctrl.sv
module tmjs_ctrl
  import tmjs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_job,
  input  status_t  status,
  output cmd_t     cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_PLACE,
    S_EMIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_job) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.seq_start = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = status.round_last ? S_EMIT : S_SCAN;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/tmjs_datapath.sv
module tmjs_datapath
  import tmjs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  output status_t   status,
  output logic      out_valid,
  output out_item_t out_item
);

  key_t                 key_mem [MAX_JOBS];
  logic [IDX_W-1:0]     order_mem [MAX_JOBS];

  logic [CNT_W-1:0]     job_count_r;
  logic [MAX_JOBS-1:0]  placed_r;
  logic [CNT_W-1:0]     scan_idx_r;
  logic [CNT_W-1:0]     round_r;
  logic [CNT_W-1:0]     front_r;
  logic [CNT_W-1:0]     back_r;
  logic [CNT_W-1:0]     emit_idx_r;

  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_job_r;
  key_t                 rd_key_r;

  logic                 best_vld_r;
  key_t                 best_key_r;
  logic [IDX_W-1:0]     best_job_r;

  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_job_r;
  logic [POS_W-1:0]     out_pos_r;
  logic                 out_last_r;

  logic [TIME_BITS-1:0] t1;
  logic [TIME_BITS-1:0] t2;
  key_t                 load_key;
  logic [CNT_W-1:0]     count_m1;
  logic [CNT_W-1:0]     back_nxt;
  logic                 take;
  logic                 has_room;

  assign t1                 = in_item.time_machine1[TIME_BITS-1:0];
  assign t2                 = in_item.time_machine2[TIME_BITS-1:0];
  assign load_key.on_second = (t2 < t1);
  assign load_key.min_time  = (t2 < t1) ? t2 : t1;
  assign has_room           = (job_count_r < CNT_W'(MAX_JOBS));
  assign count_m1           = job_count_r - CNT_W'(1);
  assign back_nxt           = back_r - CNT_W'(1);

  assign take = rd_vld_r && !placed_r[rd_job_r] &&
                (!best_vld_r || (rd_key_r.min_time < best_key_r.min_time));

  assign status.scan_last  = (scan_idx_r == count_m1);
  assign status.round_last = (round_r == count_m1);
  assign status.emit_last  = (emit_idx_r == count_m1);

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      key_mem[job_count_r[IDX_W-1:0]] <= load_key;
    end
    if (cmd.scan) begin
      rd_key_r <= key_mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      if (!best_key_r.on_second) begin
        order_mem[front_r[IDX_W-1:0]] <= best_job_r;
      end else begin
        order_mem[back_nxt[IDX_W-1:0]] <= best_job_r;
      end
    end
    if (cmd.emit) begin
      out_job_r <= order_mem[emit_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_job_r <= scan_idx_r[IDX_W-1:0];
    end
    if (take) begin
      best_key_r <= rd_key_r;
      best_job_r <= rd_job_r;
    end
    if (cmd.emit) begin
      out_pos_r  <= POS_W'(emit_idx_r);
      out_last_r <= status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r <= '0;
      placed_r    <= '0;
      scan_idx_r  <= '0;
      round_r     <= '0;
      front_r     <= '0;
      back_r      <= '0;
      emit_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      best_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.scan;
      out_vld_r <= cmd.emit;
      if (take) begin
        best_vld_r <= 1'b1;
      end
      if (cmd.load && has_room) begin
        job_count_r <= job_count_r + CNT_W'(1);
      end
      if (cmd.seq_start) begin
        round_r    <= '0;
        front_r    <= '0;
        back_r     <= job_count_r;
        scan_idx_r <= '0;
        best_vld_r <= 1'b0;
      end
      if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      if (cmd.place) begin
        placed_r[best_job_r] <= 1'b1;
        if (!best_key_r.on_second) begin
          front_r <= front_r + CNT_W'(1);
        end else begin
          back_r <= back_nxt;
        end
        round_r    <= round_r + CNT_W'(1);
        scan_idx_r <= '0;
        best_vld_r <= 1'b0;
      end
      if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        job_count_r <= '0;
        placed_r    <= '0;
        emit_idx_r  <= '0;
        scan_idx_r  <= '0;
        round_r     <= '0;
        front_r     <= '0;
        back_r      <= '0;
      end
    end
  end

  assign out_valid              = out_vld_r;
  assign out_item.job_number    = JOB_NUM_W'(out_job_r);
  assign out_item.position      = out_pos_r;
  assign out_item.last_in_order = out_last_r;

endmodule

>>> rtl/two_machine_job_sequencer.sv
// Channel   Handshake        Payload          Beat taken when
// input     start / busy     in_data          start high and busy low
// result    out_valid        out_data         out_valid high, one cycle each
//
// A job that is not marked last is taken and busy stays low.
// The last job starts sequencing: for N stored jobs each of the N rounds scans
// the key memory one job a cycle, then drains the last read and places one job;
// the single-port key scan bounds how long a set takes after its last beat.
// Results leave on consecutive cycles and cannot be stalled.
// Reset is synchronous and active low; it empties the set.
module two_machine_job_sequencer
  import tmjs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  tmjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_job (in_data.last_job),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  tmjs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

`ifndef SYNTHESIS
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while the block is idle");

  a_no_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result beat directly after an accepted job");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_in_order) |=> !busy)
    else $error("block still busy after the final result");

  a_first_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_data.position == '0))
    else $error("order does not begin at position zero");
`endif

endmodule

>>> tb/job_order_sb_pkg.sv
`timescale 1ns / 1ps
package job_order_sb_pkg;
  import tmjs_pkg::*;

  localparam int NO_TIME      = 9999;
  localparam int SHOWN_ERRORS = 10;

  class job_order_board;
    logic [TIME_BITS-1:0] m1_time [MAX_JOBS];
    logic [TIME_BITS-1:0] m2_time [MAX_JOBS];
    int unsigned          loaded;
    out_item_t            order_q[$];
    int                   errors;
    int                   shown;

    function new();
      loaded = 0;
      errors = 0;
      shown  = 0;
    endfunction

    function int pending();
      return order_q.size();
    endfunction

    // Johnson's rule: each round takes the smallest remaining time; a machine 1
    // minimum fills from the front of the order, a machine 2 minimum from the back.
    function void build_order();
      bit placed [MAX_JOBS];
      int slot   [MAX_JOBS];
      int head;
      int tail;
      int best;
      int pick;
      bit to_back;
      bit found;
      out_item_t e;
      head = 0;
      tail = loaded;
      foreach (placed[i]) placed[i] = 1'b0;
      for (int r = 0; r < loaded; r++) begin
        best    = NO_TIME;
        pick    = 0;
        to_back = 1'b0;
        found   = 1'b0;
        for (int j = 0; j < loaded; j++) begin
          if (!placed[j]) begin
            if (int'(m1_time[j]) < best) begin
              best    = int'(m1_time[j]);
              pick    = j;
              to_back = 1'b0;
              found   = 1'b1;
            end
            if (int'(m2_time[j]) < best) begin
              best    = int'(m2_time[j]);
              pick    = j;
              to_back = 1'b1;
              found   = 1'b1;
            end
          end
        end
        if (found) begin
          placed[pick] = 1'b1;
          if (!to_back) begin
            slot[head] = pick;
            head++;
          end else begin
            tail--;
            slot[tail] = pick;
          end
        end
      end
      for (int k = 0; k < loaded; k++) begin
        e.job_number    = JOB_NUM_W'(slot[k]);
        e.position      = POS_W'(k);
        e.last_in_order = (k == loaded - 1);
        order_q.push_back(e);
      end
    endfunction

    function void note_job(in_item_t job);
      if (loaded < MAX_JOBS) begin
        m1_time[loaded] = job.time_machine1[TIME_BITS-1:0];
        m2_time[loaded] = job.time_machine2[TIME_BITS-1:0];
        loaded++;
      end
      if (job.last_job) begin
        build_order();
        loaded = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (order_q.size() == 0) begin
        errors++;
        if (shown < SHOWN_ERRORS) begin
          shown++;
          $display("Unexpected beat: job %0d position %0d last %0b",
                   got.job_number, got.position, got.last_in_order);
        end
        return;
      end
      want = order_q.pop_front();
      if (got.job_number !== want.job_number || got.position !== want.position ||
          got.last_in_order !== want.last_in_order) begin
        errors++;
        if (shown < SHOWN_ERRORS) begin
          shown++;
          $display({"Mismatch: expected job %0d position %0d last %0b, ",
                    "got job %0d position %0d last %0b"},
                   want.job_number, want.position, want.last_in_order,
                   got.job_number, got.position, got.last_in_order);
        end
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tmjs_pkg::*;
  import job_order_sb_pkg::*;

  localparam int JOB_TARGET = 370;
  localparam int MAX_TIME   = (1 << TIME_W) - 1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  job_order_board board;
  int             idle_pct;
  int             sent;

  two_machine_job_sequencer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_job(in_data);
      if (out_valid) board.check_result(out_data);
    end
  end

  function automatic in_item_t make_job(int t1, int t2, bit last);
    in_item_t j;
    j.time_machine1 = TIME_W'(t1);
    j.time_machine2 = TIME_W'(t2);
    j.last_job      = last;
    return j;
  endfunction

  function automatic int pick_time(int mode);
    case (mode)
      0: return $urandom_range(7);
      1: return $urandom_range(1) ? MAX_TIME : 0;
      default: return $urandom_range(MAX_TIME);
    endcase
  endfunction

  task automatic send_job(input in_item_t job);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= job;
    do @(posedge clk); while (busy);
    sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= make_job($urandom_range(MAX_TIME), $urandom_range(MAX_TIME),
                          1'($urandom_range(1)));
      repeat ($urandom_range(5)) @(negedge clk);
    end
  endtask

  task automatic send_set(input int size, input int mode);
    for (int k = 0; k < size; k++)
      send_job(make_job(pick_time(mode), pick_time(mode), k == size - 1));
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int set_idx;
    int r;
    int size;
    int mode;
    board    = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    idle_pct = 0;
    sent     = 0;
    set_idx  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_job(make_job(0, 0, 1'b1));
    send_job(make_job(MAX_TIME, 0, 1'b0));
    send_job(make_job(0, MAX_TIME, 1'b0));
    send_job(make_job(5, 5, 1'b1));
    send_job(make_job(7, 9, 1'b0));
    send_job(make_job(7, 9, 1'b0));
    send_job(make_job(9, 7, 1'b0));
    send_job(make_job(9, 7, 1'b0));
    send_job(make_job(MAX_TIME, MAX_TIME, 1'b1));
    send_job(make_job(3, 3, 1'b0));
    send_job(make_job(3, 3, 1'b0));
    send_job(make_job(3, 3, 1'b1));
    send_job(make_job(10, 2, 1'b0));
    send_job(make_job(20, 1, 1'b0));
    send_job(make_job(30, 3, 1'b1));

    while (sent < JOB_TARGET) begin
      case (set_idx % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 13;
      endcase
      r = $urandom_range(99);
      if (r < 8)       size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      else if (r < 14) size = MAX_JOBS;
      else if (r < 30) size = $urandom_range(9, MAX_JOBS - 1);
      else             size = $urandom_range(1, 8);
      r = $urandom_range(9);
      mode = (r < 3) ? 0 : (r < 5) ? 1 : 2;
      send_set(size, mode);
      set_idx++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tmjs_pkg.sv
rtl/tmjs_ctrl.sv
rtl/tmjs_datapath.sv
rtl/two_machine_job_sequencer.sv
tb/job_order_sb_pkg.sv
tb/tb_top.sv
